/* src/kte_pkg.sv */
package kte_pkg;

  localparam int TABLE_SIZE = 16;
  localparam int KEY_BITS   = 16;
  localparam int DATA_BITS  = 32;
  localparam int CNT_W      = $clog2(TABLE_SIZE + 1);
  localparam int ENTRY_W    = 5;

  typedef enum logic [1:0] {
    OP_PUT  = 2'd0,
    OP_TAKE = 2'd1,
    OP_READ = 2'd2,
    OP_NONE = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_FULL      = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_PRESENT   = 3'd4
  } status_e;

  typedef struct packed {
    logic [1:0]           opcode;
    logic [KEY_BITS-1:0]  key;
    logic [DATA_BITS-1:0] write_data;
  } req_t;

  typedef struct packed {
    logic [DATA_BITS-1:0] read_data;
    status_e              status;
    logic [ENTRY_W-1:0]   entry_count;
  } rsp_t;

  // per-cell control from the top level
  typedef struct packed {
    logic occupied;
    logic put_load;
    logic take_en;
  } cell_ctl_t;

endpackage

/* src/kte_cell.sv */
module kte_cell
  import kte_pkg::*;
(
  input  logic                 clk_i,
  input  cell_ctl_t            ctl_i,
  input  logic [KEY_BITS-1:0]  req_key_i,
  input  logic [DATA_BITS-1:0] req_data_i,
  input  logic [KEY_BITS-1:0]  next_key_i,
  input  logic [DATA_BITS-1:0] next_data_i,
  input  logic                 hit_i,
  input  logic [DATA_BITS-1:0] data_acc_i,
  output logic [KEY_BITS-1:0]  key_o,
  output logic [DATA_BITS-1:0] data_o,
  output logic                 hit_o,
  output logic [DATA_BITS-1:0] data_acc_o
);

  logic [KEY_BITS-1:0]  key_q;
  logic [DATA_BITS-1:0] data_q;
  logic                 match;

  assign match      = ctl_i.occupied && (key_q == req_key_i);
  assign hit_o      = hit_i | match;
  assign data_acc_o = data_acc_i | (match ? data_q : '0);
  assign key_o      = key_q;
  assign data_o     = data_q;

  // a take pulls the neighbor's entry into every cell at or above the hit
  always_ff @(posedge clk_i) begin
    if (ctl_i.put_load) begin
      key_q  <= req_key_i;
      data_q <= req_data_i;
    end else if (ctl_i.take_en && hit_o) begin
      key_q  <= next_key_i;
      data_q <= next_data_i;
    end
  end

endmodule

/* src/keyed_table_engine.sv */
// channel   direction  handshake                payload
// in        input      in_valid_i / in_stall_o  in_req_i  (opcode, key, write_data)
// out       output     out_valid_o / out_stall_i out_rsp_o (read_data, status, entry_count)
//
// one request per cycle: all cells compare the key at once and the hit ripples
// up the cell chain, so lookup, removal and append finish in the accept cycle
// the response is held in an output register; a new request is taken whenever
// that register is empty or being drained, and held off while it is stalled
// reset empties the table and the output register, no clearing pass is needed
module keyed_table_engine
  import kte_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  req_t in_req_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output rsp_t out_rsp_o
);

  logic [CNT_W-1:0]     count_q, count_d;
  logic                 out_valid_q;
  rsp_t                 out_q;
  logic                 accept;
  logic                 is_put, is_take, is_lookup;
  logic                 full, empty, any_hit, put_ok, take_ok;
  status_e              status;
  logic [DATA_BITS-1:0] rdata;

  logic [KEY_BITS-1:0]  cell_key  [TABLE_SIZE];
  logic [DATA_BITS-1:0] cell_data [TABLE_SIZE];
  logic [TABLE_SIZE:0]  hit_chain;
  logic [DATA_BITS-1:0] acc_chain [TABLE_SIZE+1];

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  assign is_put    = (in_req_i.opcode == OP_PUT);
  assign is_take   = (in_req_i.opcode == OP_TAKE);
  assign is_lookup = is_take || (in_req_i.opcode == OP_READ);

  assign full    = (count_q == CNT_W'(TABLE_SIZE));
  assign empty   = (count_q == '0);
  assign any_hit = hit_chain[TABLE_SIZE];
  assign put_ok  = accept && is_put && !full && !any_hit;
  assign take_ok = accept && is_take && any_hit;

  assign hit_chain[0] = 1'b0;
  assign acc_chain[0] = '0;

  for (genvar i = 0; i < TABLE_SIZE; i++) begin : g_cell
    cell_ctl_t            ctl;
    logic [KEY_BITS-1:0]  nkey;
    logic [DATA_BITS-1:0] ndata;

    assign ctl.occupied = (count_q > CNT_W'(i));
    assign ctl.put_load = put_ok && (count_q == CNT_W'(i));
    assign ctl.take_en  = take_ok;

    if (i == TABLE_SIZE - 1) begin : g_top
      // top cell falls out of range after a take
      assign nkey  = cell_key[i];
      assign ndata = cell_data[i];
    end else begin : g_mid
      assign nkey  = cell_key[i+1];
      assign ndata = cell_data[i+1];
    end

    kte_cell u_cell (
      .clk_i       (clk_i),
      .ctl_i       (ctl),
      .req_key_i   (in_req_i.key),
      .req_data_i  (in_req_i.write_data),
      .next_key_i  (nkey),
      .next_data_i (ndata),
      .hit_i       (hit_chain[i]),
      .data_acc_i  (acc_chain[i]),
      .key_o       (cell_key[i]),
      .data_o      (cell_data[i]),
      .hit_o       (hit_chain[i+1]),
      .data_acc_o  (acc_chain[i+1])
    );
  end

  always_comb begin
    status = ST_OK;
    rdata  = '0;
    if (is_put) begin
      if (full) begin
        status = ST_FULL;
      end else if (any_hit) begin
        status = ST_PRESENT;
      end
    end else if (is_lookup) begin
      if (empty) begin
        status = ST_EMPTY;
      end else if (!any_hit) begin
        status = ST_NOT_FOUND;
      end else begin
        rdata = acc_chain[TABLE_SIZE];
      end
    end
  end

  always_comb begin
    count_d = count_q;
    if (put_ok) begin
      count_d = count_q + CNT_W'(1);
    end else if (take_ok) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q.read_data   <= rdata;
      out_q.status      <= status;
      out_q.entry_count <= ENTRY_W'(count_d);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

endmodule
